// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the color code stripping unit.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int CODE_DIGITS = 6;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  localparam logic [7:0] OPEN_CH  = 8'h7B;  // '{'
  localparam logic [7:0] CLOSE_CH = 8'h7D;  // '}'

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } out_item_t;

  // Result sequence of one input byte:
  // ['{' + ndig held digits] [the byte] ['{' of a new code] | [bare end mark]
  typedef struct packed {
    logic             open_a;
    logic [CNT_W-1:0] ndig;
    logic             byte_en;
    logic             open_b;
    logic             mark;
    logic             last;
  } plan_t;

  typedef enum logic [1:0] {
    SRC_OPEN,
    SRC_DIGIT,
    SRC_BYTE,
    SRC_MARK
  } src_t;

  typedef struct packed {
    logic             accept;
    logic             load;
    src_t             src;
    logic [IDX_W-1:0] dig_idx;
    logic             end_flag;
  } dp_cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  can_load;
  } dp_status_t;

endpackage

// ===== rtl/scc_datapath.sv =====
// ----------------------------------------------------------------------------
// scc_datapath
// Code parsing state, digit store, byte hold register and output register.
// Decodes each incoming byte into a result plan for the controller.
// ----------------------------------------------------------------------------
module scc_datapath
  import scc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   text_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic       strip_stall,
  output logic       strip_valid,
  output out_item_t  strip_data
);

  logic             collecting;
  logic             collecting_next;
  logic [CNT_W-1:0] digit_count;
  logic [CNT_W-1:0] digit_count_next;
  logic [7:0]       digit_store [CODE_DIGITS];
  logic [7:0]       hold_byte;
  logic             store_wr;
  plan_t            plan;
  out_item_t        sel_item;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  logic hex, is_open, is_close, full, last;

  always_comb begin
    hex      = is_hex(text_data.in_byte);
    is_open  = text_data.in_byte == OPEN_CH;
    is_close = text_data.in_byte == CLOSE_CH;
    last     = text_data.last_byte;
    full     = digit_count == CNT_W'(CODE_DIGITS);

    plan             = '0;
    plan.last        = last;
    store_wr         = 1'b0;
    collecting_next  = collecting;
    digit_count_next = digit_count;

    priority if (!collecting) begin
      if (is_open) begin
        collecting_next  = 1'b1;
        digit_count_next = '0;
        plan.open_a      = last;
      end else begin
        plan.byte_en = 1'b1;
      end
    end else if (hex && !full) begin
      store_wr         = 1'b1;
      digit_count_next = digit_count + CNT_W'(1);
      plan.open_a      = last;
      plan.ndig        = last ? digit_count + CNT_W'(1) : '0;
    end else if (hex) begin
      // too many digits: release and pass the digit
      plan.open_a      = 1'b1;
      plan.ndig        = digit_count;
      plan.byte_en     = 1'b1;
      collecting_next  = 1'b0;
      digit_count_next = '0;
    end else if (is_close && full) begin
      collecting_next  = 1'b0;
      digit_count_next = '0;
    end else begin
      plan.open_a = 1'b1;
      plan.ndig   = digit_count;
      if (is_open) begin
        collecting_next  = 1'b1;
        digit_count_next = '0;
        plan.open_b      = last;
      end else begin
        plan.byte_en     = 1'b1;
        collecting_next  = 1'b0;
        digit_count_next = '0;
      end
    end

    if (last) begin
      collecting_next  = 1'b0;
      digit_count_next = '0;
    end
    plan.mark = last && !(plan.open_a || plan.byte_en);
  end

  always_comb begin
    sel_item = '0;
    unique case (cmd.src)
      SRC_OPEN: begin
        sel_item.out_byte   = OPEN_CH;
        sel_item.byte_valid = 1'b1;
      end
      SRC_DIGIT: begin
        sel_item.out_byte   = digit_store[cmd.dig_idx];
        sel_item.byte_valid = 1'b1;
      end
      SRC_BYTE: begin
        sel_item.out_byte   = hold_byte;
        sel_item.byte_valid = 1'b1;
      end
      SRC_MARK: begin
        sel_item.out_byte   = '0;
        sel_item.byte_valid = 1'b0;
      end
      default: sel_item = '0;
    endcase
    sel_item.end_of_text = cmd.end_flag;
  end

  assign status.plan     = plan;
  assign status.can_load = !strip_valid || !strip_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting  <= 1'b0;
      digit_count <= '0;
      strip_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        collecting  <= collecting_next;
        digit_count <= digit_count_next;
      end
      if (cmd.load) begin
        strip_valid <= 1'b1;
      end else if (!strip_stall) begin
        strip_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_byte <= text_data.in_byte;
      if (store_wr) begin
        digit_store[digit_count[IDX_W-1:0]] <= text_data.in_byte;
      end
    end
    if (cmd.load) begin
      strip_data <= sel_item;
    end
  end

endmodule

// ===== rtl/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: takes the plan of an accepted byte and steps through its
// results, one transfer into the output register per cycle while not stalled.
// ----------------------------------------------------------------------------
module scc_ctrl
  import scc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t           state;
  plan_t            p;
  plan_t            p_next;
  logic [CNT_W-1:0] dig_idx;
  logic [CNT_W-1:0] dig_idx_next;
  src_t             src;
  logic             final_step;
  logic             step;
  logic             accept;
  logic             new_busy;

  always_comb begin
    p_next       = p;
    dig_idx_next = dig_idx;
    priority if (p.open_a) begin
      src           = SRC_OPEN;
      p_next.open_a = 1'b0;
    end else if (dig_idx != p.ndig) begin
      src          = SRC_DIGIT;
      dig_idx_next = dig_idx + CNT_W'(1);
    end else if (p.byte_en) begin
      src            = SRC_BYTE;
      p_next.byte_en = 1'b0;
    end else if (p.open_b) begin
      src           = SRC_OPEN;
      p_next.open_b = 1'b0;
    end else begin
      src         = SRC_MARK;
      p_next.mark = 1'b0;
    end
    final_step = !p_next.open_a && (dig_idx_next == p.ndig) && !p_next.byte_en &&
                 !p_next.open_b && !p_next.mark;
  end

  assign step       = (state == EMIT) && status.can_load;
  assign text_stall = !((state == IDLE) || (step && final_step));
  assign accept     = text_valid && !text_stall;
  assign new_busy   = status.plan.open_a || status.plan.byte_en || status.plan.mark;

  assign cmd.accept   = accept;
  assign cmd.load     = step;
  assign cmd.src      = src;
  assign cmd.dig_idx  = dig_idx[IDX_W-1:0];
  assign cmd.end_flag = p.last && final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      p       <= '0;
      dig_idx <= '0;
    end else if (accept) begin
      p       <= status.plan;
      dig_idx <= '0;
      state   <= new_busy ? EMIT : IDLE;
    end else if (step) begin
      p       <= p_next;
      dig_idx <= dig_idx_next;
      if (final_step) begin
        state <= IDLE;
      end
    end
  end

endmodule

// ===== rtl/strip_color_codes_unit.sv =====
// ----------------------------------------------------------------------------
// strip_color_codes_unit
// Removes inline color codes ('{' + six hex digits + '}') from a byte stream.
// ----------------------------------------------------------------------------
// Output: the results of a byte pass through the output register one per cycle
//   while strip_stall is low (up to CODE_DIGITS+2 results per byte).
// Throughput: 1 byte per cycle while each byte yields at most one result and
//   no output stall; more results per byte hold the input until all are sent.
// Reset: synchronous, active high; clears code state and empties the output.
module strip_color_codes_unit
  import scc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_stall,
  input  in_item_t  text_data,
  output logic      strip_valid,
  input  logic      strip_stall,
  output out_item_t strip_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  scc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .status     (status),
    .cmd        (cmd)
  );

  scc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .text_data   (text_data),
    .cmd         (cmd),
    .status      (status),
    .strip_stall (strip_stall),
    .strip_valid (strip_valid),
    .strip_data  (strip_data)
  );

endmodule

// ===== rtl/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_port_checks
// Port level checks for the color code stripping unit.
// ----------------------------------------------------------------------------
module scc_port_checks
  import scc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      text_valid,
  input logic      text_stall,
  input in_item_t  text_data,
  input logic      strip_valid,
  input logic      strip_stall,
  input out_item_t strip_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    strip_valid && strip_stall |=> strip_valid && $stable(strip_data))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk) rst |=> !strip_valid)
    else $error("result valid right after reset");

  // a bare end mark only closes a text
  a_mark_end: assert property (@(posedge clk) disable iff (rst)
    strip_valid && !strip_data.byte_valid |-> strip_data.end_of_text)
    else $error("bare mark without end of text");

  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    strip_valid && !strip_data.byte_valid |-> strip_data.out_byte == 8'h00)
    else $error("bare mark carries a byte");

  // handshake outputs and offered results are always known out of reset
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({text_stall, strip_valid}) &&
    (!strip_valid || !$isunknown(strip_data)))
    else $error("unknown value on a handshake or offered result");

endmodule

bind strip_color_codes_unit scc_port_checks u_port_checks (.*);
